// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// shared types and constants of the k-way sorted merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned LIST_COUNT_DEF = 8;
  localparam int unsigned LIST_DEPTH_DEF = 16;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  // input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LOADED  = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_POPPED  = 2'd2,
    STATUS_EMPTY   = 2'd3
  } kwm_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_POP,
    ST_FETCH,
    ST_DONE
  } kwm_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item, restart the head scan
    logic do_load;     // append or refuse the captured value
    logic scan_step;   // compare one list head against the running minimum
    logic pop_update;  // take the minimum, advance its list, fetch next head
    logic set_empty;   // nothing left to pop
    logic head_write;  // refill the popped list's head from memory
    logic emit;        // move the result into the output register
  } kwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;        // kind of the captured item
    logic scan_last;   // the scan is at the last list
    logic found;       // some list holds an element
    logic drain;       // the pending pop empties its list
    logic out_free;    // output register can take a result
  } kwm_sts_t;

  // sign flip maps signed order onto unsigned order
  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
    order_key = {~v[VALUE_W-1], v[VALUE_W-2:0]};
  endfunction

endpackage

// ===== rtl/kwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwm_ctrl
// sequencer for load and pop items of the sorted merge
// ----------------------------------------------------------------------------
module kwm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kwm_pkg::kwm_sts_t sts_i,
  output kwm_pkg::kwm_cmd_t cmd_o
);

  kwm_pkg::kwm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kwm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = kwm_pkg::ST_LOAD;
        end
      end
      kwm_pkg::ST_LOAD: begin
        // captured mode is visible from here on
        if (sts_i.mode == kwm_pkg::MODE_POP) begin
          state_d = kwm_pkg::ST_SCAN;
        end else begin
          cmd_o.do_load = 1'b1;
          state_d = kwm_pkg::ST_DONE;
        end
      end
      kwm_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = kwm_pkg::ST_POP;
        end
      end
      kwm_pkg::ST_POP: begin
        if (!sts_i.found) begin
          cmd_o.set_empty = 1'b1;
          state_d = kwm_pkg::ST_DONE;
        end else begin
          cmd_o.pop_update = 1'b1;
          state_d = sts_i.drain ? kwm_pkg::ST_DONE : kwm_pkg::ST_FETCH;
        end
      end
      kwm_pkg::ST_FETCH: begin
        cmd_o.head_write = 1'b1;
        state_d = kwm_pkg::ST_DONE;
      end
      kwm_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = kwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kwm_dp.sv =====
// ----------------------------------------------------------------------------
// kwm_dp
// element memory, list counters, head registers, minimum scan and result
// ----------------------------------------------------------------------------
module kwm_dp #(
  parameter int unsigned LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_mode_i,
  input  logic [kwm_pkg::INDEX_W-1:0]       in_index_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0] in_value_i,
  input  kwm_pkg::kwm_cmd_t                 cmd_i,
  output kwm_pkg::kwm_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kwm_pkg::STATUS_W-1:0]      out_status_o,
  output logic signed [kwm_pkg::VALUE_W-1:0] out_value_o,
  output logic                              out_final_o
);

  localparam int unsigned LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int unsigned FW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned AW = $clog2(LIST_COUNT * LIST_DEPTH);
  localparam int unsigned TW = $clog2(LIST_COUNT * LIST_DEPTH + 1);
  localparam int unsigned VW = kwm_pkg::VALUE_W;

  // captured item
  logic                    mode_q;
  logic [kwm_pkg::INDEX_W-1:0] index_q;
  logic [VW-1:0]           value_q;

  // per-list state
  logic [FW-1:0] fill_q [LIST_COUNT];
  logic [FW-1:0] rpos_q [LIST_COUNT];
  logic [VW-1:0] head_q [LIST_COUNT];
  logic [TW-1:0] total_q;

  // scan state
  logic [LW-1:0] scan_q;
  logic [LW-1:0] best_q;
  logic [VW-1:0] best_val_q;
  logic          found_q;

  // result and output register
  kwm_pkg::kwm_status_e res_status_q;
  logic [VW-1:0]        res_value_q;
  logic                 res_final_q;
  logic                 out_valid_q;
  logic [kwm_pkg::STATUS_W-1:0] out_status_q;
  logic [VW-1:0]        out_value_q;
  logic                 out_final_q;

  // element memory
  logic [VW-1:0] mem_q [LIST_COUNT * LIST_DEPTH];
  logic [VW-1:0] rdata_q;

  logic [LW-1:0] lidx;
  logic          in_range;
  logic          full;
  logic          load_ok;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [FW-1:0] rpos_next;
  logic          drain;
  logic [VW-1:0] scan_head;
  logic          scan_take;
  logic          rd_en;

  assign lidx     = LW'(index_q);
  assign in_range = 32'(index_q) < 32'(LIST_COUNT);
  assign full     = fill_q[lidx] >= FW'(LIST_DEPTH);
  assign load_ok  = in_range && !full;
  assign waddr    = AW'(lidx) * AW'(LIST_DEPTH) + AW'(fill_q[lidx][PW-1:0]);

  assign rpos_next = rpos_q[best_q] + FW'(1);
  assign drain     = rpos_next >= fill_q[best_q];
  assign raddr     = AW'(best_q) * AW'(LIST_DEPTH) + AW'(rpos_next[PW-1:0]);
  assign rd_en     = cmd_i.pop_update && !drain;

  assign scan_head = head_q[scan_q];
  assign scan_take = (fill_q[scan_q] != '0) &&
                     (!found_q ||
                      (kwm_pkg::order_key(scan_head) < kwm_pkg::order_key(best_val_q)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && load_ok) begin
      mem_q[waddr] <= value_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      index_q <= in_index_i;
      value_q <= in_value_i;
    end
    if (cmd_i.do_load && load_ok && (fill_q[lidx] == '0)) begin
      head_q[lidx] <= value_q;
    end
    if (cmd_i.head_write) begin
      head_q[best_q] <= rdata_q;
    end
    if (cmd_i.scan_step && scan_take) begin
      best_q     <= scan_q;
      best_val_q <= scan_head;
    end
    if (cmd_i.do_load) begin
      res_status_q <= load_ok ? kwm_pkg::STATUS_LOADED : kwm_pkg::STATUS_REFUSED;
      res_value_q  <= '0;
      res_final_q  <= 1'b0;
    end
    if (cmd_i.set_empty) begin
      res_status_q <= kwm_pkg::STATUS_EMPTY;
      res_value_q  <= '0;
      res_final_q  <= 1'b0;
    end
    if (cmd_i.pop_update) begin
      res_status_q <= kwm_pkg::STATUS_POPPED;
      res_value_q  <= best_val_q;
      res_final_q  <= total_q == TW'(1);
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_final_q  <= res_final_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= kwm_pkg::MODE_LOAD;
      scan_q      <= '0;
      found_q     <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        fill_q[i] <= '0;
        rpos_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        mode_q  <= in_mode_i;
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + LW'(1);
        if (scan_take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.do_load && load_ok) begin
        fill_q[lidx] <= fill_q[lidx] + FW'(1);
        total_q      <= total_q + TW'(1);
      end
      if (cmd_i.pop_update) begin
        total_q <= total_q - TW'(1);
        if (drain) begin
          fill_q[best_q] <= '0;
          rpos_q[best_q] <= '0;
        end else begin
          rpos_q[best_q] <= rpos_next;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.scan_last = scan_q == LW'(LIST_COUNT - 1);
  assign sts_o.found     = found_q;
  assign sts_o.drain     = drain;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_final_o  = out_final_q;

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// merges several ascending lists into one ascending stream of values
// ----------------------------------------------------------------------------
// usage:
//   the slave channel takes load and pop items. tuser is the mode (load or
//   pop), tdata carries the list index and the signed value of a load.
//   every item gives exactly one transfer on the master channel: tuser is
//   the status (loaded, refused, popped, all empty), tdata the popped value
//   (zero unless popped) and tlast marks the pop of the very last element.
//   a load is appended or refused in its load step. in a pop the head
//   registers are compared against the running minimum one list per
//   cycle, then the next head of the winning list is read from the
//   element memory through its single registered read port; a pop that
//   drains its list skips that read and goes straight to its result.
//   only one item is in flight; the next item is taken as soon as the
//   previous result sits in the output register, even if it is stalled.
//   a result waits in its final step while the output register is full.
//   reset clears all fill counts and read positions, so every list starts
//   empty; the element memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
  parameter int unsigned LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // list_index [2:0], value [34:3], zero pad
  input  logic        s_axis_tuser,   // mode
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // popped_value [31:0]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  output logic        m_axis_tlast    // final_element
);

  kwm_pkg::kwm_cmd_t cmd;
  kwm_pkg::kwm_sts_t sts;

  // sequencer: one item at a time
  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, head scan and output register
  kwm_dp #(
    .LIST_COUNT (LIST_COUNT),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mode_i    (s_axis_tuser),
    .in_index_i   (s_axis_tdata[2:0]),
    .in_value_i   (s_axis_tdata[34:3]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (m_axis_tdata),
    .out_final_o  (m_axis_tlast)
  );

  // an accepted item blocks the input until its result is made
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // only a popped result carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != kwm_pkg::STATUS_POPPED)) |->
      ((m_axis_tdata == '0) && !m_axis_tlast))
    else $error("non-pop result with value or last flag");

  // a result appears only once a scan or load step has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid)) |-> $past(!s_axis_tready))
    else $error("result issued without an item in flight");

endmodule

// ===== tb/k_way_sorted_merge_tb.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge_tb
// self-checking bench for the k-way sorted merge block
// ----------------------------------------------------------------------------
// load and pop items go in on the slave stream. Every accepted item updates a
// local copy of the list contents, and that copy yields the expected status,
// popped value and final flag. Each result transfer is checked in order
// against the oldest pending expectation. Directed items cover an empty pop,
// the signed extremes, equal heads and a full list. Random bursts load
// ascending runs and pop them back, mixed with unsorted noise. Both streams
// stall at random, except during one long stretch.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_tb;

  localparam int unsigned NLISTS     = kwm_pkg::LIST_COUNT_DEF;
  localparam int unsigned NDEPTH     = kwm_pkg::LIST_DEPTH_DEF;
  localparam int unsigned IW         = kwm_pkg::INDEX_W;
  localparam int unsigned VW         = kwm_pkg::VALUE_W;
  localparam int unsigned POP_CYCLES = NLISTS + 4;
  localparam int unsigned RUN_LIMIT  = 2_000_000;

  typedef struct {
    kwm_pkg::kwm_status_e status;
    logic [VW-1:0]        value;
    logic                 last;
  } merge_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;    // list_index [2:0], value [34:3], zero pad
  logic        s_axis_tuser  = kwm_pkg::MODE_LOAD;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // popped_value [31:0]
  logic [1:0]  m_axis_tuser;          // status [1:0]
  logic        m_axis_tlast;          // final_element

  // local copy of the lists, updated at each accepted item
  logic [VW-1:0] list_mem  [NLISTS][NDEPTH];
  int unsigned   list_fill [NLISTS] = '{default: 0};
  int unsigned   list_head [NLISTS] = '{default: 0};

  merge_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  bit            steady = 1'b0;

  k_way_sorted_merge #(
    .LIST_COUNT (NLISTS),
    .LIST_DEPTH (NDEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // applies one item to the list copy and returns what the block must answer
  function automatic merge_result_t merge_predict(logic mode, logic [IW-1:0] idx,
                                                  logic [VW-1:0] val);
    merge_result_t r;
    bit            found;
    int unsigned   best;
    int unsigned   left;
    int unsigned   i;
    r.status = kwm_pkg::STATUS_LOADED;
    r.value  = '0;
    r.last   = 1'b0;
    found    = 1'b0;
    best     = 0;
    left     = 0;
    if (mode == kwm_pkg::MODE_LOAD) begin
      if (idx >= NLISTS || list_fill[idx] >= NDEPTH) begin
        r.status = kwm_pkg::STATUS_REFUSED;
      end else begin
        list_mem[idx][list_fill[idx]] = val;
        list_fill[idx]++;
      end
      return r;
    end
    // strict compare keeps the lowest index on equal heads
    for (i = 0; i < NLISTS; i++) begin
      if (list_head[i] < list_fill[i]) begin
        left += list_fill[i] - list_head[i];
        if (!found ||
            $signed(list_mem[i][list_head[i]]) < $signed(list_mem[best][list_head[best]])) begin
          found = 1'b1;
          best  = i;
        end
      end
    end
    if (!found) begin
      r.status = kwm_pkg::STATUS_EMPTY;
      return r;
    end
    r.status = kwm_pkg::STATUS_POPPED;
    r.value  = list_mem[best][list_head[best]];
    r.last   = (left == 1);
    list_head[best]++;
    // a drained list starts over from its first slot
    if (list_head[best] >= list_fill[best]) begin
      list_head[best] = 0;
      list_fill[best] = 0;
    end
    return r;
  endfunction

  // next value for a list that keeps it ascending, saturating at the top
  function automatic logic [VW-1:0] next_sorted(logic [IW-1:0] idx);
    longint sum;
    longint step;
    if (list_fill[idx] == 0) return $urandom;
    case ($urandom_range(3))
      0: step = 0;
      1: step = longint'($urandom_range(15));
      2: step = longint'($urandom_range(65535));
      default: step = longint'($urandom >> $urandom_range(31, 1));
    endcase
    sum = longint'($signed(list_mem[idx][list_fill[idx]-1])) + step;
    if (sum > longint'(kwm_pkg::VALUE_MAX)) sum = longint'(kwm_pkg::VALUE_MAX);
    return sum[VW-1:0];
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // one item on the slave stream; valid stays high after the transfer so
  // that back-to-back items need no second assignment in the same step
  task automatic send_item(logic mode, logic [IW-1:0] idx, logic [VW-1:0] val);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 10) gap = $urandom_range(3, 1);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b0, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(merge_predict(mode, idx, val));
  endtask

  // result side stalls at random unless in the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 10);
  end

  // result checker
  always @(posedge clk_i) begin
    merge_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", {30'b0, m_axis_tuser}, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", {30'b0, m_axis_tuser}, {30'b0, want.status});
        if (m_axis_tdata !== want.value)
          report_mismatch("popped value", m_axis_tdata, want.value);
        if (m_axis_tlast !== want.last)
          report_mismatch("final flag", {31'b0, m_axis_tlast}, {31'b0, want.last});
      end
    end
  end

  // pops on an empty block, ignored fields random
  task automatic test_empty_pop();
    send_item(kwm_pkg::MODE_POP, IW'($urandom), $urandom);
    send_item(kwm_pkg::MODE_POP, IW'($urandom), $urandom);
  endtask

  // signed extremes and equal heads, popped down to the final element
  task automatic test_extremes();
    send_item(kwm_pkg::MODE_LOAD, 3'd0, 32'h8000_0000);
    send_item(kwm_pkg::MODE_LOAD, 3'd7, kwm_pkg::VALUE_MAX);
    send_item(kwm_pkg::MODE_LOAD, 3'd3, 32'h0000_0000);
    send_item(kwm_pkg::MODE_LOAD, 3'd4, 32'hffff_ffff);
    send_item(kwm_pkg::MODE_LOAD, 3'd2, 32'h0000_0007);
    send_item(kwm_pkg::MODE_LOAD, 3'd6, 32'h0000_0007);
    repeat (7) send_item(kwm_pkg::MODE_POP, IW'($urandom), $urandom);
  endtask

  // fill one list to the top, then one load too many
  task automatic test_full_list();
    int unsigned k;
    for (k = 0; k <= NDEPTH; k++) send_item(kwm_pkg::MODE_LOAD, 3'd5, 32'h1000_0000 + k);
  endtask

  // ascending bursts popped back out, with unsorted noise in between
  task automatic test_random_merge(int unsigned count);
    int unsigned sent;
    int unsigned loads;
    int unsigned pops;
    int unsigned k;
    int unsigned i;
    logic [IW-1:0] idx;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        loads = $urandom_range(24, 1);
        for (k = 0; k < loads; k++) begin
          idx = IW'($urandom_range(NLISTS - 1));
          send_item(kwm_pkg::MODE_LOAD, idx, next_sorted(idx));
        end
        if ($urandom_range(9) == 0) begin
          // drain everything and one pop past the end
          pops = 1;
          for (i = 0; i < NLISTS; i++) pops += list_fill[i] - list_head[i];
        end else begin
          pops = $urandom_range(loads + 6, loads / 2 + 1);
        end
        repeat (pops) send_item(kwm_pkg::MODE_POP, IW'($urandom), $urandom);
        sent += loads + pops;
      end else begin
        repeat (8) send_item(1'($urandom_range(1)), IW'($urandom), $urandom);
        sent += 8;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pop();
    test_extremes();
    test_full_list();
    test_random_merge(220);
    steady = 1'b1;
    test_random_merge(200);
    steady = 1'b0;
    test_random_merge(220);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * POP_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("k_way_sorted_merge_tb: clean");
    end else begin
      $display("k_way_sorted_merge_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("k_way_sorted_merge_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kwm_pkg.sv
rtl/kwm_ctrl.sv
rtl/kwm_dp.sv
rtl/k_way_sorted_merge.sv
tb/k_way_sorted_merge_tb.sv
